// ===== rtl/tlru_pkg.sv =====
// tlru_pkg: shared sizes, item types, event codes and the compare helper
// for the timestamp lru replacement core; no dependencies
`timescale 1ns / 1ps

package tlru_pkg;

  // cache geometry
  localparam int SETS = 2048;
  localparam int WAYS = 16;

  // field widths of the items
  localparam int KIND_W   = 2;
  localparam int SET_W    = 11;
  localparam int WAY_IN_W = 4;
  localparam int VICTIM_W = 4;
  localparam int STAMP_W  = 64;

  // derived sizes
  localparam int ADDR_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int WAYS_P2 = 1 << WAY_W;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_ACCESS = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SET_W-1:0]    set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic                was_hit;
    logic                is_write;
  } in_item_t;

  typedef struct packed {
    logic [VICTIM_W-1:0] victim_way;
  } out_item_t;

  // one stored row: the stamps of every way of a set
  typedef logic [WAYS-1:0][STAMP_W-1:0] row_t;

  // one node of the minimum search
  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
    logic [WAY_W-1:0]   way;
  } node_t;

  // older of two nodes; the lower way (left) wins ties
  function automatic node_t min_node(node_t a, node_t b);
    if (b.valid && (!a.valid || (b.stamp < a.stamp))) begin
      return b;
    end
    return a;
  endfunction

endpackage

// ===== rtl/tlru_in_if.sv =====
// tlru_in_if: valid/ready channel carrying one event item
// depends on tlru_pkg
`timescale 1ns / 1ps

interface tlru_in_if import tlru_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/tlru_out_if.sv =====
// tlru_out_if: valid/ready channel carrying one victim result item
// depends on tlru_pkg
`timescale 1ns / 1ps

interface tlru_out_if import tlru_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/tlru_min_tree.sv =====
// tlru_min_tree: registered pairwise tree that finds the oldest way of a row
// depends on tlru_pkg; one compare level per pipeline stage
`timescale 1ns / 1ps

module tlru_min_tree import tlru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             row_valid,
  input  row_t             row,
  output logic             way_valid,
  output logic [WAY_W-1:0] way
);

  node_t leaf [WAYS_P2];
  node_t lvl [WAY_W][WAYS_P2/2];
  logic [WAY_W-1:0] lvl_valid;

  // leaves, padding past the last way marked invalid
  for (genvar i = 0; i < WAYS_P2; i++) begin : g_leaf
    if (i < WAYS) begin : g_real
      assign leaf[i] = '{valid: 1'b1, stamp: row[i], way: WAY_W'(i)};
    end else begin : g_pad
      assign leaf[i] = '{valid: 1'b0, stamp: '0, way: WAY_W'(i)};
    end
  end

  // compare levels, each registered
  for (genvar l = 0; l < WAY_W; l++) begin : g_lvl
    for (genvar j = 0; j < (WAYS_P2 >> (l + 1)); j++) begin : g_node
      if (l == 0) begin : g_first
        always_ff @(posedge clk) begin
          lvl[l][j] <= min_node(leaf[2*j], leaf[2*j+1]);
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          lvl[l][j] <= min_node(lvl[l-1][2*j], lvl[l-1][2*j+1]);
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= '0;
    end else begin
      lvl_valid <= {lvl_valid[WAY_W-2 >= 0 ? WAY_W-2 : 0 : 0], row_valid} & {WAY_W{1'b1}};
    end
  end

  assign way_valid = lvl_valid[WAY_W-1];
  assign way       = lvl[WAY_W-1][0].way;

endmodule

// ===== rtl/timestamp_lru_replacement_core.sv =====
// timestamp_lru_replacement_core: top level, stamp memory, counter and results
// depends on tlru_pkg, tlru_in_if, tlru_out_if and tlru_min_tree
`timescale 1ns / 1ps
//
//  channel  dir  payload                                        handshake
//  cmd      in   kind, set_index, way_index, was_hit, is_write  valid/ready
//  res      out  victim_way (victim queries only)               valid/ready
//
//  a fill or access update writes its stamp as it is accepted; a new item can follow at once
//  a victim query reads its set's row into a register, then the compare tree takes
//  log2(WAYS) stages, and the result enters the output register or the pending
//  slot; one query is in flight at a time
//  after reset a clearing pass writes SETS rows, cmd.ready low
//  a result waiting on res is held in a pending slot; cmd stays closed until
//  that result has moved into the output register

module timestamp_lru_replacement_core import tlru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tlru_in_if.sink    cmd,
  tlru_out_if.source res
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] clr_addr;
  logic [STAMP_W-1:0] stamp_counter;
  logic query_busy;

  row_t stamp_mem [SETS];
  row_t rd_row;
  logic rd_valid;
  logic rd_oob;

  logic tree_valid;
  logic [WAY_W-1:0] tree_way;

  logic pend_valid;
  logic [VICTIM_W-1:0] pend_way;
  logic out_valid;
  logic [VICTIM_W-1:0] out_way;

  logic accept;
  logic is_query;
  logic set_ok;
  logic way_ok;
  logic touch;
  logic [31:0] set_ext;
  logic [31:0] way_ext;
  logic [ADDR_W-1:0] addr;
  logic [WAY_W-1:0] way_sel;
  logic [VICTIM_W-1:0] tree_res;
  logic out_free;

  // decode of the incoming item
  assign cmd.ready = (state == ST_RUN) && !query_busy;
  assign accept    = cmd.valid && cmd.ready;
  assign set_ext   = 32'(cmd.item.set_index);
  assign way_ext   = 32'(cmd.item.way_index);
  assign set_ok    = set_ext < SETS;
  assign way_ok    = way_ext < WAYS;
  assign addr      = set_ext[ADDR_W-1:0];
  assign way_sel   = way_ext[WAY_W-1:0];
  assign is_query  = cmd.item.kind == KIND_QUERY;

  always_comb begin
    case (cmd.item.kind)
      KIND_FILL:   touch = accept && set_ok && way_ok;
      KIND_ACCESS: touch = accept && set_ok && way_ok &&
                           cmd.item.was_hit && !cmd.item.is_write;
      default:     touch = 1'b0;
    endcase
  end

  // clearing pass and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
      if (32'(clr_addr) == SETS - 1) begin
        state <= ST_RUN;
      end
    end
  end

  // stamp memory: row clear, single-way stamp write, row read
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      stamp_mem[clr_addr] <= '0;
    end else if (touch) begin
      stamp_mem[addr][way_sel] <= stamp_counter;
    end
    if (accept && is_query && set_ok) begin
      rd_row <= stamp_mem[addr];
    end
    if (accept && is_query) begin
      rd_oob <= !set_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= accept && is_query;
    end
  end

  // global stamp counter
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
    end else if (touch) begin
      stamp_counter <= stamp_counter + 1'b1;
    end
  end

  tlru_min_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .row_valid (rd_valid),
    .row       (rd_row),
    .way_valid (tree_valid),
    .way       (tree_way)
  );

  // oob flag stays put while the single query is in flight
  assign tree_res = rd_oob ? '0 : VICTIM_W'(tree_way);
  assign out_free = !out_valid || res.ready;

  // output register with a pending slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      query_busy <= 1'b0;
    end else begin
      if (tree_valid && out_free) begin
        out_way    <= tree_res;
        out_valid  <= 1'b1;
        query_busy <= 1'b0;
      end else if (tree_valid) begin
        pend_way   <= tree_res;
        pend_valid <= 1'b1;
      end else if (pend_valid && out_free) begin
        out_way    <= pend_way;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
        query_busy <= 1'b0;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && is_query) begin
        query_busy <= 1'b1;
      end
    end
  end

  assign res.valid           = out_valid;
  assign res.item.victim_way = out_way;

  // checks
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("pending result without a held output");

  a_tree_while_busy: assert property (@(posedge clk) disable iff (rst)
    tree_valid |-> (query_busy && !pend_valid))
    else $error("compare tree result outside a query");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd.ready) else $error("item taken during clearing pass");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    touch |=> (stamp_counter == $past(stamp_counter) + 1'b1))
    else $error("stamp counter did not advance on a touch");

  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    !touch |=> $stable(stamp_counter)) else $error("stamp counter moved without a touch");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for timestamp_lru_replacement_core, with a victim
// scoreboard that tracks per-way use stamps and checks every victim result
// depends on tlru_pkg, tlru_in_if, tlru_out_if and the core itself
`timescale 1ns / 1ps

import tlru_pkg::*;

// tracks use stamps and the stamp counter, queues expected victim ways
class victim_scoreboard;
  bit [STAMP_W-1:0]  use_stamp [bit [SET_W+WAY_IN_W-1:0]];
  bit [STAMP_W-1:0]  stamp_count;
  bit [VICTIM_W-1:0] expected_victims [$];
  int                mismatches;

  function new();
    stamp_count = '0;
    mismatches  = 0;
  endfunction

  function bit [STAMP_W-1:0] stamp_of(int unsigned s, int unsigned w);
    bit [SET_W+WAY_IN_W-1:0] key;
    key = {s[SET_W-1:0], w[WAY_IN_W-1:0]};
    if (use_stamp.exists(key)) begin
      return use_stamp[key];
    end
    return '0;
  endfunction

  // stamp a way with the current count, then advance the count
  function void touch(int unsigned s, int unsigned w);
    if (s >= SETS || w >= WAYS) begin
      return;
    end
    use_stamp[{s[SET_W-1:0], w[WAY_IN_W-1:0]}] = stamp_count;
    stamp_count = stamp_count + 1;
  endfunction

  // oldest stamp in the set, lowest way on a tie
  function bit [VICTIM_W-1:0] oldest_way(int unsigned s);
    int unsigned best;
    if (s >= SETS) begin
      return '0;
    end
    best = 0;
    for (int unsigned w = 1; w < WAYS; w++) begin
      if (stamp_of(s, w) < stamp_of(s, best)) begin
        best = w;
      end
    end
    return best[VICTIM_W-1:0];
  endfunction

  // called for each accepted event item
  function void note_event(in_item_t ev);
    case (ev.kind)
      KIND_QUERY: begin
        expected_victims.push_back(oldest_way(ev.set_index));
      end
      KIND_FILL: begin
        touch(ev.set_index, ev.way_index);
      end
      KIND_ACCESS: begin
        if (ev.was_hit && !ev.is_write) begin
          touch(ev.set_index, ev.way_index);
        end
      end
      default: ;
    endcase
  endfunction

  // called for each accepted result item
  function void check_victim(out_item_t r);
    bit [VICTIM_W-1:0] exp_way;
    if (expected_victims.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result item, victim_way %0d", $time, r.victim_way);
      end
      return;
    end
    exp_way = expected_victims.pop_front();
    if (r.victim_way !== exp_way) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: victim_way mismatch, expected %0d got %0d",
                 $time, exp_way, r.victim_way);
      end
    end
  endfunction

  function int outstanding();
    return expected_victims.size();
  endfunction
endclass

module tb;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 10000;
  localparam int RAND_EVENTS = 500;

  logic clk;
  logic rst;

  tlru_in_if  cmd ();
  tlru_out_if res ();

  timestamp_lru_replacement_core uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  victim_scoreboard sb = new();

  int send_burst_left = 0;
  bit send_busy       = 0;
  int recv_burst_left = 0;
  bit recv_busy       = 0;
  int idle_cycles     = 0;
  int hot_sets [6];

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // wait length for one item; stretches with no waiting come and go
  function automatic int draw_wait(inout int burst_left, inout bit busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 40);
      busy = ($urandom_range(0, 2) == 0);
    end
    burst_left--;
    return busy ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic in_item_t make_event(logic [KIND_W-1:0] k, int unsigned s,
                                          int unsigned w, bit h, bit wr);
    in_item_t ev;
    ev.kind      = k;
    ev.set_index = s[SET_W-1:0];
    ev.way_index = w[WAY_IN_W-1:0];
    ev.was_hit   = h;
    ev.is_write  = wr;
    return ev;
  endfunction

  // present one event item and hold it until accepted
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = draw_wait(send_burst_left, send_busy);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.item  <= ev;
    do @(posedge clk); while (!cmd.ready);
    sb.note_event(ev);
  endtask

  // random event, mostly on a few hot sets so stamps build up
  function automatic in_item_t random_event();
    int unsigned pick;
    int unsigned s;
    logic [KIND_W-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k = KIND_QUERY;
    end else if (pick < 60) begin
      k = KIND_FILL;
    end else if (pick < 95) begin
      k = KIND_ACCESS;
    end else begin
      k = KIND_UNUSED;
    end
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom_range(0, SETS - 1);
    end else begin
      s = hot_sets[$urandom_range(0, 5)];
    end
    return make_event(k, s, $urandom_range(0, WAYS - 1),
                      ($urandom_range(0, 9) < 7), ($urandom_range(0, 9) < 3));
  endfunction

  // result side: random stalls, check each accepted result item
  initial begin
    int stall;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(recv_burst_left, recv_busy);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      sb.check_victim(res.item);
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL timestamp_lru_replacement_core");
    $finish;
  end

  // stimulus
  initial begin
    in_item_t ev;
    int n;
    rst       <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.item  <= '0;
    hot_sets[0] = 0;
    hot_sets[1] = SETS - 1;
    for (int i = 2; i < 6; i++) begin
      hot_sets[i] = $urandom_range(0, SETS - 1);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: ties after reset, extreme sets and ways, every kind
    send_event(make_event(KIND_QUERY, 0, 0, 0, 0));
    send_event(make_event(KIND_QUERY, SETS - 1, WAYS - 1, 1, 1));
    send_event(make_event(KIND_FILL, 3, WAYS - 1, 1, 1));
    send_event(make_event(KIND_FILL, 3, 0, 0, 0));
    send_event(make_event(KIND_QUERY, 3, WAYS - 1, 0, 0));
    send_event(make_event(KIND_FILL, 3, 1, 0, 1));
    send_event(make_event(KIND_FILL, 3, 2, 1, 0));
    send_event(make_event(KIND_QUERY, 3, 5, 1, 1));
    send_event(make_event(KIND_ACCESS, 3, WAYS - 1, 1, 0));
    send_event(make_event(KIND_ACCESS, 3, 3, 1, 1));
    send_event(make_event(KIND_ACCESS, 3, 3, 0, 0));
    send_event(make_event(KIND_ACCESS, 3, 4, 0, 1));
    send_event(make_event(KIND_UNUSED, 3, 3, 1, 0));
    send_event(make_event(KIND_QUERY, 3, 0, 0, 0));
    send_event(make_event(KIND_FILL, SETS - 1, WAYS - 1, 0, 0));
    send_event(make_event(KIND_ACCESS, SETS - 1, 0, 1, 0));
    send_event(make_event(KIND_QUERY, SETS - 1, 0, 0, 0));
    send_event(make_event(KIND_FILL, 0, 0, 0, 0));
    send_event(make_event(KIND_QUERY, 0, WAYS - 1, 0, 0));

    // random part; one pause in the middle until all results are back
    n = 0;
    while (n < RAND_EVENTS) begin
      if (n == RAND_EVENTS / 2) begin
        cmd.valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      ev = random_event();
      send_event(ev);
      if (ev.kind != KIND_UNUSED) begin
        n++;
      end
    end
    cmd.valid <= 1'b0;

    // drain, then allow time for any stray result item
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS timestamp_lru_replacement_core");
    end else begin
      $display("FAIL timestamp_lru_replacement_core");
    end
    $finish;
  end
endmodule
